@@ hw/rtl/b64c_pkg.sv @@
// ----------------------------------------------------------------------------
// b64c_pkg
// shared types, codes and alphabet functions for the base64 codec
// ----------------------------------------------------------------------------
package b64c_pkg;

  // mode register codes
  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  // results one input word can cause at most
  localparam int unsigned MaxResults = 4;

  // decoded symbol codes beyond the 64 alphabet values
  localparam logic [6:0] SymPad = 7'd64;
  localparam logic [6:0] SymBad = 7'd65;

  localparam logic [7:0] CharPad = 8'h3d;  // '='

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_stream;
    logic       bad_char;
  } out_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] val);
    logic [7:0] w;
    w = {2'b00, val};
    if (val < 6'd26) begin
      return w + 8'h41;            // 'A'
    end else if (val < 6'd52) begin
      return w + 8'h47;            // 'a' - 26
    end else if (val < 6'd62) begin
      return w - 8'h04;            // '0' - 52
    end else if (val == 6'd62) begin
      return 8'h2b;                // '+'
    end else begin
      return 8'h2f;                // '/'
    end
  endfunction

  // character to symbol value, pad or bad
  function automatic logic [6:0] dec_sym(input logic [7:0] ch);
    logic [7:0] w;
    w = 8'h00;
    case (ch) inside
      [8'h41:8'h5a]: begin
        w = ch - 8'h41;
        return w[6:0];
      end
      [8'h61:8'h7a]: begin
        w = ch - 8'h47;
        return w[6:0];
      end
      [8'h30:8'h39]: begin
        w = ch + 8'h04;
        return w[6:0];
      end
      8'h2b:   return 7'd62;
      8'h2f:   return 7'd63;
      CharPad: return SymPad;
      default: return SymBad;
    endcase
  endfunction

endpackage

@@ hw/rtl/base64_codec.sv @@
// ----------------------------------------------------------------------------
// base64_codec
// streaming base64 encoder / decoder, one byte per input word
// ----------------------------------------------------------------------------
// path: an accepted word is registered in the input register, then its results are
//   loaded into the result buffer, whose slot 0 drives the output
// throughput: one word per cycle while each gives at most one result and the output
//   does not stall; otherwise the next word waits until the final result leaves
// reset: asynchronous, clears valid flags, mode (encode) and the group state
module base64_codec (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input words
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  b64c_pkg::in_t     in_data_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output b64c_pkg::out_t    out_data_o,
  // mode register write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_mode_i
);

  localparam int unsigned MaxRes = b64c_pkg::MaxResults;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  // input register
  logic          item_valid_q;
  b64c_pkg::in_t item_q;

  // mode and group state
  logic        mode_q;
  logic [23:0] gb_q, gb_d;
  logic [1:0]  gc_q, gc_d;
  logic [1:0]  pad_q, pad_d;

  // result buffer, slot 0 drives the output
  b64c_pkg::out_t       buf_q [MaxRes];
  b64c_pkg::out_t       buf_d [MaxRes];
  logic [CntW-1:0]      buf_cnt_q, buf_cnt_d;

  // results of the word in the input register
  logic [7:0]      res_byte [MaxRes];
  logic            res_bad  [MaxRes];
  logic [CntW-1:0] res_n;

  logic out_fire, load, cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  assign out_valid_o = (buf_cnt_q != '0);
  assign out_data_o  = buf_q[0];
  assign out_fire    = out_valid_o & out_ready_i;

  // move the word on once the buffer is empty or its final entry leaves now
  assign load = item_valid_q &&
                ((buf_cnt_q == '0) || ((buf_cnt_q == CntW'(1)) && out_fire));

  // the input register frees up in the same cycle its word moves on
  assign in_ready_o = !item_valid_q || load;

  // --------------------------------------------------------------------------
  // per-word work: next group state and the list of results
  // --------------------------------------------------------------------------
  always_comb begin
    logic [7:0]  b;
    logic [23:0] enc_gb;
    logic [2:0]  cnt;
    logic [23:0] v;
    logic [6:0]  sym;
    logic        is_pad, is_bad_sym, bad;
    logic [23:0] dgb;
    logic [1:0]  dpad;
    logic [23:0] gb_a;
    logic [1:0]  gc_a, pad_a;
    logic [7:0]  f_byte [2];
    logic        f_bad  [2];
    logic [1:0]  fn;
    logic [1:0]  nb;

    b          = item_q.data_byte;
    gb_d       = gb_q;
    gc_d       = gc_q;
    pad_d      = pad_q;
    res_n      = '0;
    for (int i = 0; i < MaxRes; i++) begin
      res_byte[i] = 8'h00;
      res_bad[i]  = 1'b0;
    end
    enc_gb     = {gb_q[15:0], b};
    cnt        = {1'b0, gc_q} + 3'd1;
    v          = '0;
    sym        = b64c_pkg::dec_sym(b);
    is_pad     = (sym == b64c_pkg::SymPad);
    is_bad_sym = (sym == b64c_pkg::SymBad);
    bad        = is_bad_sym || (is_pad && (gc_q < 2'd2)) ||
                 (!is_pad && !is_bad_sym && (pad_q != 2'd0));
    dgb        = {gb_q[17:0], sym[5:0]};     // pad appends zeros
    dpad       = pad_q + {1'b0, is_pad};
    gb_a       = gb_q;
    gc_a       = gc_q;
    pad_a      = pad_q;
    f_byte[0]  = 8'h00;
    f_byte[1]  = 8'h00;
    f_bad[0]   = 1'b0;
    f_bad[1]   = 1'b0;
    fn         = 2'd0;
    nb         = 2'd3 - dpad;

    if (mode_q == b64c_pkg::ModeEncode) begin
      if (cnt == 3'd3) begin
        // full group: four characters
        res_byte[0] = b64c_pkg::enc_char(enc_gb[23:18]);
        res_byte[1] = b64c_pkg::enc_char(enc_gb[17:12]);
        res_byte[2] = b64c_pkg::enc_char(enc_gb[11:6]);
        res_byte[3] = b64c_pkg::enc_char(enc_gb[5:0]);
        res_n       = CntW'(4);
        gb_d        = '0;
        gc_d        = 2'd0;
      end else begin
        gb_d = enc_gb;
        gc_d = cnt[1:0];
        if (item_q.last) begin
          // partial group flush with '=' padding
          v           = (cnt == 3'd1) ? {b, 16'h0000} : {enc_gb[15:0], 8'h00};
          res_byte[0] = b64c_pkg::enc_char(v[23:18]);
          res_byte[1] = b64c_pkg::enc_char(v[17:12]);
          res_byte[2] = (cnt == 3'd2) ? b64c_pkg::enc_char(v[11:6])
                                      : b64c_pkg::CharPad;
          res_byte[3] = b64c_pkg::CharPad;
          res_n       = CntW'(4);
        end
      end
    end else begin
      // state after this character
      if (!bad) begin
        if (cnt == 3'd4) begin
          gb_a  = '0;
          gc_a  = 2'd0;
          pad_a = dpad;
        end else begin
          gb_a  = dgb;
          gc_a  = cnt[1:0];
          pad_a = dpad;
        end
      end
      // end of stream with an open group
      if (item_q.last && (gc_a != 2'd0)) begin
        if ((pad_a == 2'd0) && (gc_a == 2'd2)) begin
          f_byte[0] = gb_a[11:4];
          fn        = 2'd1;
        end else if ((pad_a == 2'd0) && (gc_a == 2'd3)) begin
          f_byte[0] = gb_a[17:10];
          f_byte[1] = gb_a[9:2];
          fn        = 2'd2;
        end else begin
          f_bad[0] = 1'b1;
          fn       = 2'd1;
        end
      end
      // result list: error first, then the flush
      if (bad) begin
        res_bad[0]  = 1'b1;
        res_byte[1] = f_byte[0];
        res_bad[1]  = f_bad[0];
        res_byte[2] = f_byte[1];
        res_bad[2]  = f_bad[1];
        res_n       = CntW'(fn) + CntW'(1);
      end else if (cnt == 3'd4) begin
        res_byte[0] = dgb[23:16];
        res_byte[1] = dgb[15:8];
        res_byte[2] = dgb[7:0];
        res_n       = CntW'(nb);
      end else begin
        res_byte[0] = f_byte[0];
        res_bad[0]  = f_bad[0];
        res_byte[1] = f_byte[1];
        res_bad[1]  = f_bad[1];
        res_n       = CntW'(fn);
      end
      gb_d  = gb_a;
      gc_d  = gc_a;
      pad_d = pad_a;
    end

    // stream end always restarts from an empty group
    if (item_q.last) begin
      gb_d  = '0;
      gc_d  = 2'd0;
      pad_d = 2'd0;
    end
  end

  // --------------------------------------------------------------------------
  // result buffer next value: load a new list or shift one word out
  // --------------------------------------------------------------------------
  always_comb begin
    buf_cnt_d = buf_cnt_q;
    for (int i = 0; i < MaxRes; i++) begin
      buf_d[i] = buf_q[i];
    end
    if (load) begin
      for (int i = 0; i < MaxRes; i++) begin
        buf_d[i].out_byte      = res_byte[i];
        buf_d[i].bad_char      = res_bad[i];
        buf_d[i].last_of_run   = (CntW'(i) + CntW'(1) == res_n);
        buf_d[i].end_of_stream = (CntW'(i) + CntW'(1) == res_n) && item_q.last;
      end
      buf_cnt_d = res_n;
    end else if (out_fire) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      buf_cnt_d = buf_cnt_q - CntW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      buf_cnt_q    <= '0;
      mode_q       <= b64c_pkg::ModeEncode;
      gb_q         <= '0;
      gc_q         <= 2'd0;
      pad_q        <= 2'd0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      buf_cnt_q <= buf_cnt_d;
      if (cfg_fire) begin
        // a mode write starts a fresh group
        mode_q <= cfg_mode_i;
        gb_q   <= '0;
        gc_q   <= 2'd0;
        pad_q  <= 2'd0;
      end else if (load) begin
        gb_q  <= gb_d;
        gc_q  <= gc_d;
        pad_q <= pad_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    for (int i = 0; i < MaxRes; i++) begin
      buf_q[i] <= buf_d[i];
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && item_q.last) |-> (res_n != '0))
    else $error("stream end produced no result");

  a_last_clears_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && item_q.last && !cfg_fire) |=>
      ((gb_q == '0) && (gc_q == 2'd0) && (pad_q == 2'd0)))
    else $error("group state not cleared after stream end");

  a_pad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_q != 2'd3)
    else $error("more than two pad characters counted");

  a_enc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == b64c_pkg::ModeEncode) |-> (gc_q != 2'd3))
    else $error("encode group count overflow");

  a_final_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && (buf_cnt_q == CntW'(1))) |-> out_data_o.last_of_run)
    else $error("final buffered word lacks last_of_run");

endmodule
